// ===== rtl/assert_macros.svh =====
// Assertion shorthands for the checker modules.
// Each expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that is checked at every rising edge outside reset.
`define PCORR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// An implication: when the antecedent holds, the consequent must hold too.
`define PCORR_ASSERT_IMPL(lbl, ante, cons, msg) \
	`PCORR_ASSERT(lbl, (ante) |-> (cons), msg)

// An implication whose consequent is checked in the cycle after the antecedent.
`define PCORR_ASSERT_NEXT(lbl, ante, cons, msg) \
	`PCORR_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/pcorr_pkg.sv =====
package pcorr_pkg;

	localparam int MaxWindow  = 1024;
	localparam int SampleBits = 24;
	localparam int SampleW    = 24;
	localparam int CountW     = $clog2(MaxWindow + 2);
	localparam int SumW       = 34;
	localparam int SqW        = 58;
	localparam int SqProdW    = 2 * SampleW;
	localparam int SampCntW   = $clog2(SampleW);
	localparam int MulW       = 68;
	localparam int ProdW      = 2 * MulW;
	localparam int MulCntW    = $clog2(MulW);
	localparam int DiffW      = 70;
	localparam int FracShift  = 30;
	localparam int DivW       = ProdW + FracShift;
	localparam int DivCntW    = $clog2(DivW);
	localparam int QuotW      = FracShift + 1;
	localparam int RootW      = 16;
	localparam int RadW       = 2 * RootW;
	localparam int RemW       = RootW + 3;
	localparam int RootCntW   = $clog2(RootW);
	localparam int CorrW      = 16;
	localparam int StatusW    = 3;

	typedef enum logic [StatusW-1:0] {
		ST_OK        = 3'd0,
		ST_NONFINITE = 3'd1,
		ST_SHORT     = 3'd2,
		ST_LONG      = 3'd3,
		ST_ZEROVAR   = 3'd4
	} status_t;

	typedef struct packed {
		logic signed [SumW-1:0] sx;
		logic signed [SumW-1:0] sy;
		logic signed [SqW-1:0]  sxx;
		logic signed [SqW-1:0]  syy;
		logic signed [SqW-1:0]  sxy;
		logic [CountW-1:0]      count;
		logic                   saw_nonfinite;
	} window_sums_t;

	// Keeps the low SampleBits bits of a sample and sign-extends them.
	function automatic logic signed [SampleW-1:0] sext_sample(input logic [SampleW-1:0] raw);
		logic [SampleW-1:0] up;
		up = raw << (SampleW - SampleBits);
		return $signed(up) >>> (SampleW - SampleBits);
	endfunction

	function automatic logic [MulW-1:0] mag_sum(input logic signed [SumW-1:0] v);
		logic signed [SumW-1:0] n;
		n = -v;
		return v[SumW-1] ? MulW'(unsigned'(n)) : MulW'(unsigned'(v));
	endfunction

	function automatic logic [MulW-1:0] mag_sq(input logic signed [SqW-1:0] v);
		logic signed [SqW-1:0] n;
		n = -v;
		return v[SqW-1] ? MulW'(unsigned'(n)) : MulW'(unsigned'(v));
	endfunction

endpackage

// ===== rtl/pcorr_if.sv =====
interface pcorr_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [pcorr_pkg::SampleW-1:0]  sample_x;
	logic signed [pcorr_pkg::SampleW-1:0]  sample_y;
	logic                                  sample_finite;
	logic                                  last_sample;

	modport source (output valid, sample_x, sample_y, sample_finite, last_sample,
		input ready);
	modport sink (input valid, sample_x, sample_y, sample_finite, last_sample,
		output ready);
	modport mon (input valid, ready, sample_x, sample_y, sample_finite, last_sample);
endinterface

interface pcorr_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [pcorr_pkg::CorrW-1:0]  correlation;
	logic [pcorr_pkg::StatusW-1:0]       status;

	modport source (output valid, correlation, status, input ready);
	modport sink (input valid, correlation, status, output ready);
	modport mon (input valid, ready, correlation, status);
endinterface

// ===== rtl/window_pearson_correlation_core.sv =====
// Pearson correlation over a window of paired samples.
// The samples channel carries one pair (sample_x, sample_y, both signed Q8.16) per
// beat, with sample_finite and last_sample flags. The result channel carries one
// beat per window: the correlation in signed Q1.15 and a status code.
// A pair steps through the accumulator states idle, multiply, add and done when
// it is finite and accepted into the sums (the bit-serial products step through
// the 24 sample bits), and from idle straight to done when it is non-finite or
// beyond the window limit. Samples are taken one pair at a time: ready is high
// only while the accumulator is idle. The last pair hands the sums to the finishing
// unit, which offers the result beat after eight multiplications on the shared
// serial multiplier (one shift step per bit of the 68-bit operands), a restoring
// division, a square root and the load of the output register. A short, over-long
// or non-finite window skips the arithmetic; one without positive variance stops
// after the first four multiplications. The next window is accumulated meanwhile;
// its last pair waits only if the finishing unit is busy. The result sits in an
// output register, so a stalled receiver at first holds the beat without blocking
// accumulation; the following result then waits, and a later last pair behind it.
// Reset clears the sums, the count and all handshake state; no clearing pass.
module window_pearson_correlation_core (
	input  logic        clk,
	input  logic        arst_n,
	pcorr_in_if.sink    samples,
	pcorr_out_if.source result
);
	// Sums handed from the accumulator to the finishing unit at window end.
	pcorr_pkg::window_sums_t sums;
	logic                    sums_valid;
	logic                    sums_ready;

	pcorr_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.sums       (sums),
		.sums_valid (sums_valid),
		.sums_ready (sums_ready)
	);

	// The finishing unit owns the output register of the result channel.
	pcorr_finish u_finish (
		.clk        (clk),
		.arst_n     (arst_n),
		.sums       (sums),
		.sums_valid (sums_valid),
		.sums_ready (sums_ready),
		.result     (result)
	);
endmodule

// ===== rtl/pcorr_mul.sv =====
// Shift-and-add multiplier: one bit of b per cycle, product ready when done pulses.
module pcorr_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pcorr_pkg::MulW-1:0]    a,
	input  logic [pcorr_pkg::MulW-1:0]    b,
	output logic                          done,
	output logic [pcorr_pkg::ProdW-1:0]   p
);
	logic [pcorr_pkg::ProdW-1:0]   acc_q;
	logic [pcorr_pkg::MulW-1:0]    a_q;
	logic [pcorr_pkg::MulW-1:0]    b_q;
	logic [pcorr_pkg::MulCntW-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [pcorr_pkg::MulW:0]      sum;

	assign sum  = {1'b0, acc_q[pcorr_pkg::ProdW-1:pcorr_pkg::MulW]} +
		(b_q[0] ? {1'b0, a_q} : '0);
	assign done = done_q;
	assign p    = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q &&
				(cnt_q == pcorr_pkg::MulCntW'(pcorr_pkg::MulW - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pcorr_pkg::MulCntW'(pcorr_pkg::MulW - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[pcorr_pkg::MulW-1:1]};
			b_q   <= b_q >> 1;
		end
	end
endmodule

// ===== rtl/pcorr_accum.sv =====
// Takes one sample pair at a time, forms the three products bit-serially and
// keeps the window sums. At the end of a window the sums are handed on and cleared.
module pcorr_accum (
	input  logic                      clk,
	input  logic                      arst_n,
	pcorr_in_if.sink                  samples,
	output pcorr_pkg::window_sums_t   sums,
	output logic                      sums_valid,
	input  logic                      sums_ready
);
	typedef enum logic [3:0] {
		A_IDLE = 4'b0001,
		A_MUL  = 4'b0010,
		A_ADD  = 4'b0100,
		A_DONE = 4'b1000
	} acc_state_t;

	acc_state_t                           state_q;
	logic signed [pcorr_pkg::SumW-1:0]    sx_q, sy_q;
	logic signed [pcorr_pkg::SqW-1:0]     sxx_q, syy_q, sxy_q;
	logic [pcorr_pkg::CountW-1:0]         count_q;
	logic                                 nf_q;
	logic                                 last_q;
	logic                                 sgn_q;
	logic [pcorr_pkg::SqProdW-1:0]        ax_q, ay_q;
	logic [pcorr_pkg::SampleW-1:0]        bx_q, by_q;
	logic [pcorr_pkg::SqProdW-1:0]        pxx_q, pyy_q, pxy_q;
	logic [pcorr_pkg::SampCntW-1:0]       cnt_q;

	logic                                 accept;
	logic signed [pcorr_pkg::SampleW-1:0] x, y, nx, ny;
	logic [pcorr_pkg::SampleW-1:0]        mx, my;
	logic signed [pcorr_pkg::SqW-1:0]     ext_xx, ext_yy, ext_xy;

	assign samples.ready = (state_q == A_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign x  = pcorr_pkg::sext_sample(samples.sample_x);
	assign y  = pcorr_pkg::sext_sample(samples.sample_y);
	assign nx = -x;
	assign ny = -y;
	assign mx = x[pcorr_pkg::SampleW-1] ? unsigned'(nx) : unsigned'(x);
	assign my = y[pcorr_pkg::SampleW-1] ? unsigned'(ny) : unsigned'(y);

	assign ext_xx = signed'(pcorr_pkg::SqW'(pxx_q));
	assign ext_yy = signed'(pcorr_pkg::SqW'(pyy_q));
	assign ext_xy = signed'(pcorr_pkg::SqW'(pxy_q));

	assign sums_valid          = (state_q == A_DONE) && last_q;
	assign sums.sx             = sx_q;
	assign sums.sy             = sy_q;
	assign sums.sxx            = sxx_q;
	assign sums.syy            = syy_q;
	assign sums.sxy            = sxy_q;
	assign sums.count          = count_q;
	assign sums.saw_nonfinite  = nf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			sx_q    <= '0;
			sy_q    <= '0;
			sxx_q   <= '0;
			syy_q   <= '0;
			sxy_q   <= '0;
			count_q <= '0;
			nf_q    <= 1'b0;
			last_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				A_IDLE: begin
					if (accept) begin
						last_q <= samples.last_sample;
						if (count_q >= pcorr_pkg::CountW'(pcorr_pkg::MaxWindow)) begin
							count_q <= pcorr_pkg::CountW'(pcorr_pkg::MaxWindow + 1);
							state_q <= A_DONE;
						end else begin
							count_q <= count_q + 1'b1;
							if (!samples.sample_finite) begin
								nf_q    <= 1'b1;
								state_q <= A_DONE;
							end else begin
								sx_q    <= sx_q + pcorr_pkg::SumW'(x);
								sy_q    <= sy_q + pcorr_pkg::SumW'(y);
								cnt_q   <= '0;
								state_q <= A_MUL;
							end
						end
					end
				end
				A_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == pcorr_pkg::SampCntW'(pcorr_pkg::SampleW - 1)) begin
						state_q <= A_ADD;
					end
				end
				A_ADD: begin
					sxx_q   <= sxx_q + ext_xx;
					syy_q   <= syy_q + ext_yy;
					sxy_q   <= sgn_q ? (sxy_q - ext_xy) : (sxy_q + ext_xy);
					state_q <= A_DONE;
				end
				A_DONE: begin
					if (!last_q) begin
						state_q <= A_IDLE;
					end else if (sums_ready) begin
						sx_q    <= '0;
						sy_q    <= '0;
						sxx_q   <= '0;
						syy_q   <= '0;
						sxy_q   <= '0;
						count_q <= '0;
						nf_q    <= 1'b0;
						state_q <= A_IDLE;
					end
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	// Three product lanes: xx shifts on the bits of x, while yy and xy share the bits of y.
	always_ff @(posedge clk) begin
		if (accept) begin
			sgn_q <= x[pcorr_pkg::SampleW-1] ^ y[pcorr_pkg::SampleW-1];
			ax_q  <= pcorr_pkg::SqProdW'(mx);
			ay_q  <= pcorr_pkg::SqProdW'(my);
			bx_q  <= mx;
			by_q  <= my;
			pxx_q <= '0;
			pyy_q <= '0;
			pxy_q <= '0;
		end else if (state_q == A_MUL) begin
			if (bx_q[0]) begin
				pxx_q <= pxx_q + ax_q;
			end
			if (by_q[0]) begin
				pyy_q <= pyy_q + ay_q;
				pxy_q <= pxy_q + ax_q;
			end
			ax_q <= ax_q << 1;
			ay_q <= ay_q << 1;
			bx_q <= bx_q >> 1;
			by_q <= by_q >> 1;
		end
	end
endmodule

// ===== rtl/pcorr_finish.sv =====
// Turns the window sums into a correlation: for a clean window, eight serial multiplications,
// a restoring division and a digit-by-digit square root; a window that fails early gets only a status.
module pcorr_finish (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pcorr_pkg::window_sums_t  sums,
	input  logic                     sums_valid,
	output logic                     sums_ready,
	pcorr_out_if.source              result
);
	typedef enum logic [4:0] {
		F_IDLE = 5'b00001,
		F_MUL  = 5'b00010,
		F_DIV  = 5'b00100,
		F_SQRT = 5'b01000,
		F_OUT  = 5'b10000
	} fin_state_t;

	typedef enum logic [2:0] {
		STEP_WSXX  = 3'd0,
		STEP_SXSX  = 3'd1,
		STEP_WSYY  = 3'd2,
		STEP_SYSY  = 3'd3,
		STEP_WSXY  = 3'd4,
		STEP_SXSY  = 3'd5,
		STEP_VXVY  = 3'd6,
		STEP_NUMSQ = 3'd7
	} step_t;

	fin_state_t                            state_q;
	step_t                                 step_q;
	pcorr_pkg::window_sums_t               sums_q;
	logic                                  start_q;
	logic signed [pcorr_pkg::DiffW-1:0]    tmp_q;
	logic [pcorr_pkg::MulW-1:0]            vx_q, vy_q, nmag_q;
	logic                                  vx_bad_q;
	logic                                  neg_q;
	logic [pcorr_pkg::ProdW-1:0]           prod_q;
	logic [pcorr_pkg::DivW-1:0]            dividend_q;
	logic [pcorr_pkg::ProdW-1:0]           rem_q;
	logic [pcorr_pkg::QuotW-1:0]           quot_q;
	logic [pcorr_pkg::DivCntW-1:0]         div_cnt_q;
	logic [pcorr_pkg::RadW-1:0]            rad_q;
	logic [pcorr_pkg::RootW-1:0]           root_q;
	logic [pcorr_pkg::RemW-1:0]            srem_q;
	logic [pcorr_pkg::RootCntW-1:0]        root_cnt_q;
	logic signed [pcorr_pkg::CorrW-1:0]    res_corr_q;
	pcorr_pkg::status_t                    res_status_q;
	logic                                  out_valid_q;
	logic signed [pcorr_pkg::CorrW-1:0]    corr_q;
	pcorr_pkg::status_t                    status_q;

	logic [pcorr_pkg::MulW-1:0]            op_a, op_b;
	logic                                  mul_done;
	logic [pcorr_pkg::ProdW-1:0]           mul_p;
	logic [pcorr_pkg::MulW-1:0]            w_ext;
	logic signed [pcorr_pkg::DiffW-1:0]    p_lo, p_neg, diff, num, num_neg;
	logic                                  diff_bad;
	logic                                  start_d;
	logic [pcorr_pkg::ProdW:0]             r2, r2_sub;
	logic                                  qbit;
	logic [pcorr_pkg::QuotW-1:0]           quot_d;
	logic [pcorr_pkg::RemW-1:0]            r_in, trial, r_sub;
	logic                                  rbit;
	logic [pcorr_pkg::RootW-1:0]           root_d;
	logic signed [pcorr_pkg::CorrW-1:0]    corr_d;

	assign sums_ready         = (state_q == F_IDLE);
	assign result.valid       = out_valid_q;
	assign result.correlation = corr_q;
	assign result.status      = status_q;

	assign w_ext = pcorr_pkg::MulW'(sums_q.count);

	always_comb begin
		case (step_q)
			STEP_WSXX:  begin op_a = w_ext; op_b = pcorr_pkg::mag_sq(sums_q.sxx); end
			STEP_SXSX:  begin
				op_a = pcorr_pkg::mag_sum(sums_q.sx);
				op_b = pcorr_pkg::mag_sum(sums_q.sx);
			end
			STEP_WSYY:  begin op_a = w_ext; op_b = pcorr_pkg::mag_sq(sums_q.syy); end
			STEP_SYSY:  begin
				op_a = pcorr_pkg::mag_sum(sums_q.sy);
				op_b = pcorr_pkg::mag_sum(sums_q.sy);
			end
			STEP_WSXY:  begin op_a = w_ext; op_b = pcorr_pkg::mag_sq(sums_q.sxy); end
			STEP_SXSY:  begin
				op_a = pcorr_pkg::mag_sum(sums_q.sx);
				op_b = pcorr_pkg::mag_sum(sums_q.sy);
			end
			STEP_VXVY:  begin op_a = vx_q; op_b = vy_q; end
			STEP_NUMSQ: begin op_a = nmag_q; op_b = nmag_q; end
			default:    begin op_a = '0; op_b = '0; end
		endcase
	end

	pcorr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.a      (op_a),
		.b      (op_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	// Partial products are bounded well below the 70-bit working width.
	assign p_lo     = signed'({1'b0, mul_p[pcorr_pkg::DiffW-2:0]});
	assign p_neg    = -p_lo;
	assign diff     = tmp_q - p_lo;
	assign diff_bad = diff[pcorr_pkg::DiffW-1] || (diff == '0);
	assign num      = tmp_q -
		((sums_q.sx[pcorr_pkg::SumW-1] ^ sums_q.sy[pcorr_pkg::SumW-1]) ? p_neg : p_lo);
	assign num_neg  = -num;

	// A multiplication starts after a clean window is taken and after every product but
	// the last, except that it stops once both variances are formed and either is not positive.
	assign start_d = ((state_q == F_IDLE) && sums_valid &&
			(sums.count >= pcorr_pkg::CountW'(2)) &&
			(sums.count <= pcorr_pkg::CountW'(pcorr_pkg::MaxWindow)) &&
			!sums.saw_nonfinite) ||
		((state_q == F_MUL) && mul_done && (step_q != STEP_NUMSQ) &&
			!((step_q == STEP_SYSY) && (vx_bad_q || diff_bad)));

	// Restoring division, one quotient bit per cycle.
	assign r2     = {rem_q, dividend_q[pcorr_pkg::DivW-1]};
	assign r2_sub = r2 - {1'b0, prod_q};
	assign qbit   = !r2_sub[pcorr_pkg::ProdW];
	assign quot_d = {quot_q[pcorr_pkg::QuotW-2:0], qbit};

	// Square root, one result bit per cycle.
	assign r_in   = {srem_q[pcorr_pkg::RemW-3:0], rad_q[pcorr_pkg::RadW-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign r_sub  = r_in - trial;
	assign rbit   = (r_in >= trial);
	assign root_d = {root_q[pcorr_pkg::RootW-2:0], rbit};

	always_comb begin
		if (neg_q) begin
			corr_d = -signed'(root_d);
		end else if (root_d[pcorr_pkg::RootW-1]) begin
			corr_d = {1'b0, {(pcorr_pkg::CorrW-1){1'b1}}};
		end else begin
			corr_d = signed'(root_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_IDLE;
			step_q       <= STEP_WSXX;
			start_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			div_cnt_q    <= '0;
			root_cnt_q   <= '0;
		end else begin
			start_q <= start_d;
			if (result.valid && result.ready && (state_q != F_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				F_IDLE: begin
					if (sums_valid) begin
						step_q <= STEP_WSXX;
						if (sums.count < pcorr_pkg::CountW'(2)) begin
							state_q <= F_OUT;
						end else if (sums.count > pcorr_pkg::CountW'(pcorr_pkg::MaxWindow)) begin
							state_q <= F_OUT;
						end else if (sums.saw_nonfinite) begin
							state_q <= F_OUT;
						end else begin
							state_q <= F_MUL;
						end
					end
				end
				F_MUL: begin
					if (mul_done) begin
						if (step_q == STEP_NUMSQ) begin
							div_cnt_q <= '0;
							state_q   <= F_DIV;
						end else if (step_q == STEP_SYSY && (vx_bad_q || diff_bad)) begin
							state_q <= F_OUT;
						end else begin
							step_q <= step_t'(step_q + 3'd1);
						end
					end
				end
				F_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == pcorr_pkg::DivCntW'(pcorr_pkg::DivW - 1)) begin
						root_cnt_q <= '0;
						state_q    <= F_SQRT;
					end
				end
				F_SQRT: begin
					root_cnt_q <= root_cnt_q + 1'b1;
					if (root_cnt_q == pcorr_pkg::RootCntW'(pcorr_pkg::RootW - 1)) begin
						state_q <= F_OUT;
					end
				end
				F_OUT: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						state_q     <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				sums_q     <= sums;
				res_corr_q <= '0;
				if (sums.count < pcorr_pkg::CountW'(2)) begin
					res_status_q <= pcorr_pkg::ST_SHORT;
				end else if (sums.count > pcorr_pkg::CountW'(pcorr_pkg::MaxWindow)) begin
					res_status_q <= pcorr_pkg::ST_LONG;
				end else if (sums.saw_nonfinite) begin
					res_status_q <= pcorr_pkg::ST_NONFINITE;
				end else begin
					res_status_q <= pcorr_pkg::ST_OK;
				end
			end
			F_MUL: begin
				if (mul_done) begin
					case (step_q)
						STEP_WSXX, STEP_WSYY: tmp_q <= p_lo;
						STEP_SXSX: begin
							vx_q     <= diff[pcorr_pkg::MulW-1:0];
							vx_bad_q <= diff_bad;
						end
						STEP_SYSY: begin
							vy_q <= diff[pcorr_pkg::MulW-1:0];
							if (vx_bad_q || diff_bad) begin
								res_status_q <= pcorr_pkg::ST_ZEROVAR;
							end
						end
						STEP_WSXY: tmp_q <= sums_q.sxy[pcorr_pkg::SqW-1] ? p_neg : p_lo;
						STEP_SXSY: begin
							neg_q  <= num[pcorr_pkg::DiffW-1];
							nmag_q <= num[pcorr_pkg::DiffW-1] ?
								num_neg[pcorr_pkg::MulW-1:0] : num[pcorr_pkg::MulW-1:0];
						end
						STEP_VXVY: prod_q <= mul_p;
						STEP_NUMSQ: begin
							dividend_q <= {mul_p, {pcorr_pkg::FracShift{1'b0}}};
							rem_q      <= '0;
							quot_q     <= '0;
						end
						default: tmp_q <= tmp_q;
					endcase
				end
			end
			F_DIV: begin
				dividend_q <= dividend_q << 1;
				rem_q      <= qbit ? r2_sub[pcorr_pkg::ProdW-1:0] : r2[pcorr_pkg::ProdW-1:0];
				quot_q     <= quot_d;
				if (div_cnt_q == pcorr_pkg::DivCntW'(pcorr_pkg::DivW - 1)) begin
					rad_q  <= pcorr_pkg::RadW'(quot_d);
					root_q <= '0;
					srem_q <= '0;
				end
			end
			F_SQRT: begin
				rad_q  <= rad_q << 2;
				srem_q <= rbit ? r_sub : r_in;
				root_q <= root_d;
				if (root_cnt_q == pcorr_pkg::RootCntW'(pcorr_pkg::RootW - 1)) begin
					res_corr_q <= corr_d;
				end
			end
			F_OUT: begin
				if (!out_valid_q || result.ready) begin
					corr_q   <= res_corr_q;
					status_q <= res_status_q;
				end
			end
			default: tmp_q <= tmp_q;
		endcase
	end
endmodule

// ===== rtl/pcorr_checker.sv =====
`include "assert_macros.svh"

module pcorr_checker (
	input logic         clk,
	input logic         arst_n,
	pcorr_out_if.source result
);
	`PCORR_ASSERT_NEXT(a_valid_held, result.valid && !result.ready, result.valid, "result beat dropped while stalled")
	`PCORR_ASSERT_NEXT(a_payload_held, result.valid && !result.ready, $stable(result.correlation) && $stable(result.status), "result payload changed while stalled")
	`PCORR_ASSERT_IMPL(a_error_zero, result.valid && (result.status != pcorr_pkg::ST_OK), result.correlation == '0, "error result carries a non-zero correlation")
	`PCORR_ASSERT_IMPL(a_status_known, result.valid, result.status <= pcorr_pkg::ST_ZEROVAR, "unknown status code")
endmodule

bind window_pearson_correlation_core pcorr_checker u_pcorr_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.result (result)
);

// ===== verif/tb_window_pearson_correlation_core.sv =====
`default_nettype none

module tb_window_pearson_correlation_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SampleW   = pcorr_pkg::SampleW;
	localparam int CorrW     = pcorr_pkg::CorrW;
	localparam int MaxWindow = pcorr_pkg::MaxWindow;
	localparam int FracShift = pcorr_pkg::FracShift;

	typedef pcorr_pkg::status_t status_t;

	// Extremes of a signed Q8.16 sample.
	localparam logic signed [SampleW-1:0] SampleMax = {1'b0, {(SampleW-1){1'b1}}};
	localparam logic signed [SampleW-1:0] SampleMin = {1'b1, {(SampleW-1){1'b0}}};
	// Cycles without any accepted beat before the run is declared hung.
	localparam int HangLimit = 20000;
	// Length of the deliberate receiver hold-off.
	localparam int LongHold = 3000;

	typedef struct {
		logic signed [SampleW-1:0] x;
		logic signed [SampleW-1:0] y;
		bit                        finite;
		bit                        last;
	} pair_t;

	typedef struct {
		logic signed [CorrW-1:0] corr;
		status_t                 status;
	} corr_result_t;

	logic clk;
	logic arst_n;

	pcorr_in_if  samples_if();
	pcorr_out_if result_if();

	window_pearson_correlation_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_if.sink),
		.result (result_if.source)
	);

	// Pairs waiting to be offered, and results the block still owes us.
	pair_t        pending_pairs[$];
	corr_result_t owed_results[$];

	// Our own copy of the window accumulators.
	longint      win_sx, win_sy, win_sxx, win_syy, win_sxy;
	int unsigned win_count;
	bit          win_nonfinite;

	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned status_seen[5];
	int unsigned hold_requests;
	int unsigned hold_served;
	int unsigned idle_cycles;

	// Clock and a single reset at the start of the run.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Exact correlation of the current window, truncated to Q1.15. The magnitude is
	// the largest q with q^2 * vx * vy <= num^2 * 2^30, capped at one.
	function automatic void window_correlation(output logic signed [CorrW-1:0] corr,
		output status_t status);
		logic signed [139:0] n_w, s_x, s_y, s_xx, s_yy, s_xy, num, var_x, var_y;
		logic [139:0]        num_mag;
		logic [299:0]        lhs, var_prod, rhs;
		int unsigned         q, t;
		corr = '0;
		if (win_count < 2) begin
			status = pcorr_pkg::ST_SHORT;
			return;
		end
		if (win_count > MaxWindow) begin
			status = pcorr_pkg::ST_LONG;
			return;
		end
		if (win_nonfinite) begin
			status = pcorr_pkg::ST_NONFINITE;
			return;
		end
		n_w  = 140'(win_count);
		s_x  = 140'(win_sx);
		s_y  = 140'(win_sy);
		s_xx = 140'(win_sxx);
		s_yy = 140'(win_syy);
		s_xy = 140'(win_sxy);
		num   = n_w * s_xy - s_x * s_y;
		var_x = n_w * s_xx - s_x * s_x;
		var_y = n_w * s_yy - s_y * s_y;
		if (var_x <= 0 || var_y <= 0) begin
			status = pcorr_pkg::ST_ZEROVAR;
			return;
		end
		status   = pcorr_pkg::ST_OK;
		num_mag  = (num < 0) ? -num : num;
		lhs      = (300'(num_mag) * 300'(num_mag)) << FracShift;
		var_prod = 300'(unsigned'(var_x)) * 300'(unsigned'(var_y));
		q = 0;
		for (int b = 15; b >= 0; b--) begin
			t = q | (32'd1 << b);
			if (t <= 32768) begin
				rhs = 300'(t) * 300'(t) * var_prod;
				if (rhs <= lhs)
					q = t;
			end
		end
		if (num < 0)
			corr = 16'(-$signed(17'(q)));
		else
			corr = (q > 32767) ? 16'sd32767 : 16'(q);
	endfunction

	// Folds one accepted pair into the window; on the last pair of a window it
	// queues the result the block must produce and starts a fresh window.
	function automatic void accumulate_pair(input pair_t p);
		longint       xv, yv;
		corr_result_t r;
		if (win_count >= MaxWindow) begin
			win_count = MaxWindow + 1;
		end else begin
			win_count++;
			if (!p.finite) begin
				win_nonfinite = 1'b1;
			end else begin
				xv = longint'(p.x);
				yv = longint'(p.y);
				win_sx  += xv;
				win_sy  += yv;
				win_sxx += xv * xv;
				win_syy += yv * yv;
				win_sxy += xv * yv;
			end
		end
		if (p.last) begin
			window_correlation(r.corr, r.status);
			owed_results = {owed_results, r};
			win_sx = 0;
			win_sy = 0;
			win_sxx = 0;
			win_syy = 0;
			win_sxy = 0;
			win_count = 0;
			win_nonfinite = 1'b0;
		end
	endfunction

	task automatic add_pair(input logic signed [SampleW-1:0] x, input logic signed [SampleW-1:0] y,
		input bit finite, input bit last);
		pair_t p;
		p.x = x;
		p.y = y;
		p.finite = finite;
		p.last = last;
		pending_pairs = {pending_pairs, p};
	endtask

	// A random window. Most windows are short and well formed, with content chosen
	// so that the correlation lands anywhere from -1 to +1; a few are degenerate.
	task automatic add_random_window();
		int                        len, flavour, gain;
		logic signed [SampleW-1:0] x, y;
		bit                        finite;
		flavour = $urandom_range(0, 9);
		case ($urandom_range(0, 19))
			0:       len = 1;
			1, 2:    len = $urandom_range(20, 60);
			default: len = $urandom_range(2, 10);
		endcase
		gain = $urandom_range(0, 1) ? 1 : -1;
		for (int i = 0; i < len; i++) begin
			x = SampleW'($urandom);
			y = SampleW'($urandom);
			case (flavour)
				0, 1: begin
					// Strongly related series with a little noise.
					x = SampleW'($signed(SampleW'($urandom_range(0, 1 << 21))) - (1 << 20));
					y = SampleW'(gain * x + $signed(SampleW'($urandom_range(0, 63))) - 32);
				end
				2: begin
					// Exactly proportional series.
					x = SampleW'($signed(SampleW'($urandom_range(0, 1 << 20))) - (1 << 19));
					y = SampleW'(gain * x);
				end
				3: x = 24'sd4096;
				4: begin
					x = SampleW'($signed(SampleW'($urandom_range(0, 255))) - 128);
					y = SampleW'($signed(SampleW'($urandom_range(0, 255))) - 128);
				end
				default: ;
			endcase
			finite = ($urandom_range(0, 99) >= 3);
			add_pair(x, y, finite, i == len - 1);
		end
	endtask

	// Sender: bursts of random length separated by random gaps.
	int unsigned burst_left;
	int unsigned gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_if.valid         <= 1'b0;
			samples_if.sample_x      <= '0;
			samples_if.sample_y      <= '0;
			samples_if.sample_finite <= 1'b0;
			samples_if.last_sample   <= 1'b0;
			burst_left               <= 8;
			gap_left                 <= 0;
		end else begin
			if (samples_if.valid && samples_if.ready) begin
				accumulate_pair(pending_pairs.pop_front());
			end
			if (!samples_if.valid || samples_if.ready) begin
				if (gap_left > 0) begin
					gap_left         <= gap_left - 1;
					samples_if.valid <= 1'b0;
				end else if (pending_pairs.size() > 0) begin
					samples_if.valid         <= 1'b1;
					samples_if.sample_x      <= pending_pairs[0].x;
					samples_if.sample_y      <= pending_pairs[0].y;
					samples_if.sample_finite <= pending_pairs[0].finite;
					samples_if.last_sample   <= pending_pairs[0].last;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					samples_if.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: a stall pattern whose character is redrawn at random intervals, plus a long
	// hold-off whenever the stimulus asks for one.
	int unsigned hold_left;
	int unsigned mode_left;
	int unsigned ready_pct;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			hold_left       <= 0;
			hold_served     <= 0;
			mode_left       <= 0;
			ready_pct       <= 100;
		end else if (hold_left > 0) begin
			hold_left       <= hold_left - 1;
			result_if.ready <= 1'b0;
		end else if (hold_served != hold_requests) begin
			hold_served     <= hold_served + 1;
			hold_left       <= LongHold;
			result_if.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				mode_left <= $urandom_range(50, 400);
				case ($urandom_range(0, 3))
					0:       ready_pct <= 100;
					1:       ready_pct <= 15;
					default: ready_pct <= 65;
				endcase
			end else begin
				mode_left <= mode_left - 1;
			end
			result_if.ready <= ($urandom_range(0, 99) < ready_pct);
		end
	end

	// Result checker: every result beat is compared with the oldest owed result.
	always @(posedge clk) begin
		corr_result_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			results_seen++;
			if (result_if.status < 5)
				status_seen[result_if.status]++;
			if (owed_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result beat: correlation %0d status %0d", $realtime,
						result_if.correlation, result_if.status);
			end else begin
				want = owed_results.pop_front();
				if (result_if.correlation !== want.corr || result_if.status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result mismatch: expected correlation %0d status %0d, got %0d status %0d",
							$realtime, want.corr, want.status, result_if.correlation, result_if.status);
				end
			end
		end
	end

	// Hang detector: any stretch with no beat on either channel that is far longer
	// than a finishing pass behind a full receiver hold-off ends the run.
	always @(posedge clk) begin
		if (!arst_n || (samples_if.valid && samples_if.ready) ||
			(result_if.valid && result_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= HangLimit) begin
			$display("Timeout: no beat for %0d cycles, %0d results outstanding",
				idle_cycles, owed_results.size());
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic wait_drained();
		while (pending_pairs.size() > 0 || samples_if.valid || owed_results.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		mismatches = 0;
		results_seen = 0;
		hold_requests = 0;
		idle_cycles = 0;
		foreach (status_seen[i])
			status_seen[i] = 0;

		// Directed windows. A single pair is too short, even when it is non-finite.
		add_pair(24'sd100, 24'sd200, 1'b1, 1'b1);
		add_pair(24'sd100, 24'sd200, 1'b0, 1'b1);
		// Opposite extremes give exactly minus one; identical series saturate at one.
		add_pair(SampleMax, SampleMin, 1'b1, 1'b0);
		add_pair(SampleMin, SampleMax, 1'b1, 1'b1);
		add_pair(SampleMin, SampleMin, 1'b1, 1'b0);
		add_pair(SampleMax, SampleMax, 1'b1, 1'b1);
		add_pair(24'sd1, 24'sd1, 1'b1, 1'b0);
		add_pair(24'sd2, 24'sd2, 1'b1, 1'b1);
		// A constant first series has no variance.
		add_pair(24'sd65536, 24'sd5, 1'b1, 1'b0);
		add_pair(24'sd65536, -24'sd9, 1'b1, 1'b0);
		add_pair(24'sd65536, 24'sd77, 1'b1, 1'b1);
		// A non-finite pair inside the window, and one on its last pair.
		add_pair(24'sd10, 24'sd20, 1'b1, 1'b0);
		add_pair(24'sd30, 24'sd40, 1'b0, 1'b0);
		add_pair(-24'sd50, 24'sd60, 1'b1, 1'b1);
		add_pair(24'sd10, 24'sd20, 1'b1, 1'b0);
		add_pair(-24'sd30, 24'sd40, 1'b0, 1'b1);
		// A general window with every sample bit toggling.
		add_pair(24'sh555555, 24'shAAAAAA, 1'b1, 1'b0);
		add_pair(24'shAAAAAA, 24'sh555555, 1'b1, 1'b0);
		add_pair(24'sh0F0F0F, 24'sh123456, 1'b1, 1'b0);
		add_pair(-24'sd1, 24'sd0, 1'b1, 1'b1);

		// The sender pauses here until every owed result has been delivered.
		wait_drained();

		// The receiver holds off for a long stretch while pairs keep coming, so that
		// the output register and the finishing unit back up into the input.
		hold_requests++;
		for (int i = 0; i < 40; i++)
			add_random_window();
		wait_drained();

		// One window longer than the limit; the excess pairs are dropped.
		for (int i = 0; i <= MaxWindow; i++)
			add_pair(SampleW'($urandom), SampleW'($urandom), 1'b1, i == MaxWindow);

		while (pending_pairs.size() < 1300)
			add_random_window();
		hold_requests++;
		while (pending_pairs.size() < 1560)
			add_random_window();
		wait_drained();

		// Let any trailing activity settle before judging the run.
		repeat (200) @(posedge clk);

		$display("Checked %0d windows: %0d ok, %0d non-finite, %0d short, %0d too long, %0d flat",
			results_seen, status_seen[pcorr_pkg::ST_OK], status_seen[pcorr_pkg::ST_NONFINITE],
			status_seen[pcorr_pkg::ST_SHORT], status_seen[pcorr_pkg::ST_LONG],
			status_seen[pcorr_pkg::ST_ZEROVAR]);
		$display("Stimulus included extreme samples, exact plus and minus one, and long receiver stalls.");
		if (mismatches == 0 && owed_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches, %0d results never delivered", mismatches, owed_results.size());
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire
